>>> src/sfb_pkg.sv
// Shared constants, types and helpers for the seam feather blender.
`timescale 1ns / 1ps
`default_nettype none

package sfb_pkg;

    // Geometry of the frame and of the register fields.
    localparam int MAX_COLUMNS = 4096;
    localparam int COL_W       = 12;
    localparam int CFG_W       = 13;
    localparam int CH_W        = 8;
    localparam int CFG_INDEX_W = 2;

    // Blend arithmetic: numerator, reciprocal and their product.
    localparam int NUM_W       = 20;
    localparam int MUL_W       = 21;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_STEPS = RECIP_W;
    localparam int STEP_W      = 5;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [CFG_W-1:0]   cfg_word_t;
    typedef logic [CH_W-1:0]    chan_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [MUL_W-1:0]   mul_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [QPTR_W-1:0]  qptr_t;
    typedef logic [QCNT_W-1:0]  qcnt_t;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COPY_WIDTH  = 2'd0,
        REG_BLEND_START = 2'd1,
        REG_BLEND_END   = 2'd2,
        REG_DARK_LEVEL  = 2'd3
    } reg_index_t;

    // Register values after reset.
    localparam cfg_word_t COPY_WIDTH_RST  = 13'd0;
    localparam cfg_word_t BLEND_START_RST = 13'd0;
    localparam cfg_word_t BLEND_END_RST   = 13'd640;
    localparam chan_t     DARK_LEVEL_RST  = 8'd50;

    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        cfg_word_t copy_width;
        cfg_word_t blend_start;
        cfg_word_t blend_end;
        chan_t     dark_level;
    } cfg_t;

    // One classified pixel waiting for the back end.
    typedef struct packed {
        logic      mix;
        pixel_t    pass;
        pixel_t    refp;
        pixel_t    base;
        cfg_word_t wref;
        cfg_word_t wbase;
    } item_t;

    // Column registers saturate at the frame width.
    function automatic cfg_word_t clamp_cols(input cfg_word_t v);
        cfg_word_t lim;
        lim = cfg_word_t'(MAX_COLUMNS);
        return (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

>>> src/sfb_recip.sv
// Bit-serial unit that forms floor(2^24 / span) for the blend divider.
`timescale 1ns / 1ps
`default_nettype none

module sfb_recip (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               restart,
    input  wire sfb_pkg::cfg_word_t span,
    output      sfb_pkg::recip_t    recip,
    output      logic               busy
);

    sfb_pkg::step_t     cnt_reg;
    sfb_pkg::step_t     cnt_next;
    sfb_pkg::cfg_word_t rem_reg;
    sfb_pkg::cfg_word_t rem_next;
    sfb_pkg::recip_t    quot_reg;
    sfb_pkg::recip_t    quot_next;
    logic               in_bit;
    logic [sfb_pkg::CFG_W:0] rem_sh;
    logic [sfb_pkg::CFG_W:0] span_ext;
    logic               ge;

    assign busy  = (cnt_reg != '0);
    assign recip = quot_reg;

    // One restoring division step: the dividend is a single one at the top bit.
    always_comb
    begin
        in_bit    = (cnt_reg == sfb_pkg::step_t'(sfb_pkg::RECIP_STEPS));
        rem_sh    = {rem_reg, in_bit};
        span_ext  = {1'b0, span};
        ge        = (rem_sh >= span_ext);
        rem_next  = ge ? sfb_pkg::cfg_word_t'(rem_sh - span_ext)
                       : rem_sh[sfb_pkg::CFG_W-1:0];
        quot_next = {quot_reg[sfb_pkg::RECIP_W-2:0], ge};
        cnt_next  = cnt_reg - sfb_pkg::step_t'(1);
    end

    // Reset and every window write start a fresh division.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= sfb_pkg::step_t'(sfb_pkg::RECIP_STEPS);
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (restart)
        begin
            cnt_reg  <= sfb_pkg::step_t'(sfb_pkg::RECIP_STEPS);
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy)
        begin
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sfb_front.sv
// Front end: accepts pixels and sorts them into copy, pass or blend.
`timescale 1ns / 1ps
`default_nettype none

module sfb_front (
    input  wire logic                     start,
    input  wire logic [sfb_pkg::COL_W-1:0] column,
    input  wire sfb_pkg::pixel_t          warp,
    input  wire sfb_pkg::pixel_t          refp,
    input  wire sfb_pkg::cfg_t            cfg,
    input  wire logic                     recip_busy,
    input  wire logic                     queue_full,
    output      logic                     busy,
    output      logic                     push,
    output      sfb_pkg::item_t           item
);

    sfb_pkg::cfg_word_t col;
    sfb_pkg::pixel_t    base;
    logic               in_win;
    logic               dark;

    // Hold off new words while the reciprocal is stale or the queue is full.
    assign busy = recip_busy || queue_full;
    assign push = start && !busy;

    // Pick the base pixel, test the window and the darkness of the base.
    always_comb
    begin
        col    = {1'b0, column};
        base   = (col < cfg.copy_width) ? refp : warp;
        in_win = (cfg.blend_end > cfg.blend_start) &&
                 (col >= cfg.blend_start) && (col < cfg.blend_end);
        dark   = (base.blue < cfg.dark_level) && (base.green < cfg.dark_level) &&
                 (base.red < cfg.dark_level);

        item.mix   = in_win && !dark;
        item.pass  = (in_win && dark) ? refp : base;
        item.refp  = refp;
        item.base  = base;
        item.wref  = cfg.blend_end - col;
        item.wbase = col - cfg.blend_start;
    end

endmodule

`default_nettype wire

>>> src/sfb_queue.sv
// Short queue that decouples the front end from the blend pipeline.
`timescale 1ns / 1ps
`default_nettype none

module sfb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sfb_pkg::item_t push_item,
    input  wire logic           pop,
    output      logic           valid,
    output      logic           full,
    output      sfb_pkg::item_t head
);

    sfb_pkg::item_t mem_reg [sfb_pkg::QUEUE_DEPTH];
    sfb_pkg::qptr_t wr_ptr_reg;
    sfb_pkg::qptr_t rd_ptr_reg;
    sfb_pkg::qcnt_t cnt_reg;
    sfb_pkg::qcnt_t cnt_next;

    assign valid = (cnt_reg != '0);
    assign full  = (cnt_reg == sfb_pkg::qcnt_t'(sfb_pkg::QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && valid))
        begin
            cnt_next = cnt_reg + sfb_pkg::qcnt_t'(1);
        end
        else if (!push && pop && valid)
        begin
            cnt_next = cnt_reg - sfb_pkg::qcnt_t'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sfb_pkg::qptr_t'(1);
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + sfb_pkg::qptr_t'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> src/sfb_back.sv
// Back end: weighted sum, reciprocal multiply, one-step correction, output.
`timescale 1ns / 1ps
`default_nettype none

module sfb_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire sfb_pkg::item_t     in_item,
    input  wire sfb_pkg::cfg_word_t span,
    input  wire sfb_pkg::recip_t    recip,
    output      logic               pop,
    output      logic               out_valid,
    output      sfb_pkg::pixel_t    out_pix
);

    sfb_pkg::chan_t  ref_ch  [3];
    sfb_pkg::chan_t  base_ch [3];
    sfb_pkg::chan_t  pass_ch [3];
    sfb_pkg::num_t   num_next [3];
    sfb_pkg::prod_t  prod    [3];
    sfb_pkg::mul_t   chk     [3];
    sfb_pkg::mul_t   rem     [3];
    sfb_pkg::chan_t  res_ch  [3];

    logic            s1_valid_reg;
    logic            s1_mix_reg;
    sfb_pkg::pixel_t s1_pass_reg;
    sfb_pkg::num_t   s1_num_reg [3];

    logic            s2_valid_reg;
    logic            s2_mix_reg;
    sfb_pkg::chan_t  s2_pass_reg [3];
    sfb_pkg::num_t   s2_num_reg  [3];
    sfb_pkg::chan_t  s2_q_reg    [3];

    logic            out_valid_reg;
    sfb_pkg::pixel_t out_pix_reg;

    // The result side never stalls, so a waiting word is always taken.
    assign pop       = in_valid;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

    // Stage one: weighted numerator per channel.
    always_comb
    begin
        ref_ch[0]  = in_item.refp.blue;
        ref_ch[1]  = in_item.refp.green;
        ref_ch[2]  = in_item.refp.red;
        base_ch[0] = in_item.base.blue;
        base_ch[1] = in_item.base.green;
        base_ch[2] = in_item.base.red;
        for (int c = 0; c < 3; c++)
        begin
            num_next[c] = sfb_pkg::num_t'(
                sfb_pkg::mul_t'(ref_ch[c]) * sfb_pkg::mul_t'(in_item.wref) +
                sfb_pkg::mul_t'(base_ch[c]) * sfb_pkg::mul_t'(in_item.wbase));
        end
    end

    // Stage two: estimate by the reciprocal, never above the true quotient.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = sfb_pkg::prod_t'(s1_num_reg[c]) * sfb_pkg::prod_t'(recip);
        end
        pass_ch[0] = s1_pass_reg.blue;
        pass_ch[1] = s1_pass_reg.green;
        pass_ch[2] = s1_pass_reg.red;
    end

    // Stage three: the estimate is at most one short, so one compare settles it.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chk[c] = sfb_pkg::mul_t'(s2_q_reg[c]) * sfb_pkg::mul_t'(span);
            rem[c] = sfb_pkg::mul_t'(s2_num_reg[c]) - chk[c];
            if (!s2_mix_reg)
            begin
                res_ch[c] = s2_pass_reg[c];
            end
            else if (rem[c] >= sfb_pkg::mul_t'(span))
            begin
                res_ch[c] = s2_q_reg[c] + sfb_pkg::chan_t'(1);
            end
            else
            begin
                res_ch[c] = s2_q_reg[c];
            end
        end
    end

    // Valid flags through the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Data registers of the three stages.
    always_ff @(posedge clk)
    begin
        s1_mix_reg  <= in_item.mix;
        s1_pass_reg <= in_item.pass;
        s2_mix_reg  <= s1_mix_reg;
        for (int c = 0; c < 3; c++)
        begin
            s1_num_reg[c]  <= num_next[c];
            s2_num_reg[c]  <= s1_num_reg[c];
            s2_pass_reg[c] <= pass_ch[c];
            s2_q_reg[c]    <= prod[c][sfb_pkg::RECIP_SHIFT +: sfb_pkg::CH_W];
        end
        out_pix_reg.blue  <= res_ch[0];
        out_pix_reg.green <= res_ch[1];
        out_pix_reg.red   <= res_ch[2];
    end

endmodule

`default_nettype wire

>>> src/seam_feather_blend_top.sv
// Top level of the seam feather blender: registers, front, queue, back.
//
//  Channel   Direction  Handshake                  Payload
//  pixel     in         start, busy                column, warp_*, ref_*
//  result    out        out_valid (one cycle)      out_blue, out_green, out_red
//  config    in         cfg_valid, cfg_ready       cfg_index, cfg_data
//
// One pixel word is taken per clock while busy is low; its result passes through the
// queue and the back-end stages and appears one cycle wide. After reset, and after
// every write to blend_start or blend_end, busy stays high while the serial unit
// forms the reciprocal of the window width, one quotient bit a cycle. Reset is
// asynchronous and active low. The receiver cannot stall, so the queue drains every
// cycle and busy otherwise only rises on a full queue.
`timescale 1ns / 1ps
`default_nettype none

module seam_feather_blend_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic [sfb_pkg::COL_W-1:0]       column,
    input  wire logic [sfb_pkg::CH_W-1:0]        warp_blue,
    input  wire logic [sfb_pkg::CH_W-1:0]        warp_green,
    input  wire logic [sfb_pkg::CH_W-1:0]        warp_red,
    input  wire logic [sfb_pkg::CH_W-1:0]        ref_blue,
    input  wire logic [sfb_pkg::CH_W-1:0]        ref_green,
    input  wire logic [sfb_pkg::CH_W-1:0]        ref_red,
    output      logic                            out_valid,
    output      logic [sfb_pkg::CH_W-1:0]        out_blue,
    output      logic [sfb_pkg::CH_W-1:0]        out_green,
    output      logic [sfb_pkg::CH_W-1:0]        out_red,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [sfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfb_pkg::CFG_W-1:0]       cfg_data
);

    sfb_pkg::cfg_t       cfg_reg;
    sfb_pkg::cfg_t       cfg_next;
    sfb_pkg::reg_index_t cfg_sel;
    logic                cfg_wr;
    logic                recip_restart;
    sfb_pkg::cfg_word_t  span;
    sfb_pkg::recip_t     recip;
    logic                recip_busy;
    sfb_pkg::pixel_t     warp;
    sfb_pkg::pixel_t     refp;
    sfb_pkg::item_t      push_item;
    sfb_pkg::item_t      head;
    logic                push;
    logic                queue_full;
    logic                queue_valid;
    logic                pop;
    sfb_pkg::pixel_t     out_pix;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_sel   = sfb_pkg::reg_index_t'(cfg_index);
    assign recip_restart = cfg_wr && ((cfg_sel == sfb_pkg::REG_BLEND_START) ||
                                      (cfg_sel == sfb_pkg::REG_BLEND_END));
    assign span      = cfg_reg.blend_end - cfg_reg.blend_start;

    assign warp.blue  = warp_blue;
    assign warp.green = warp_green;
    assign warp.red   = warp_red;
    assign refp.blue  = ref_blue;
    assign refp.green = ref_green;
    assign refp.red   = ref_red;

    assign out_blue  = out_pix.blue;
    assign out_green = out_pix.green;
    assign out_red   = out_pix.red;

    // Register write decode; column registers saturate at the frame width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_sel)
                sfb_pkg::REG_COPY_WIDTH:  cfg_next.copy_width  = sfb_pkg::clamp_cols(cfg_data);
                sfb_pkg::REG_BLEND_START: cfg_next.blend_start = sfb_pkg::clamp_cols(cfg_data);
                sfb_pkg::REG_BLEND_END:   cfg_next.blend_end   = sfb_pkg::clamp_cols(cfg_data);
                sfb_pkg::REG_DARK_LEVEL:  cfg_next.dark_level  = cfg_data[sfb_pkg::CH_W-1:0];
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.copy_width  <= sfb_pkg::COPY_WIDTH_RST;
            cfg_reg.blend_start <= sfb_pkg::BLEND_START_RST;
            cfg_reg.blend_end   <= sfb_pkg::BLEND_END_RST;
            cfg_reg.dark_level  <= sfb_pkg::DARK_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Reciprocal of the window width.
    sfb_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (recip_restart),
        .span    (span),
        .recip   (recip),
        .busy    (recip_busy)
    );

    // Accept and classify.
    sfb_front u_front (
        .start      (start),
        .column     (column),
        .warp       (warp),
        .refp       (refp),
        .cfg        (cfg_reg),
        .recip_busy (recip_busy),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .item       (push_item)
    );

    // Queue between the two halves.
    sfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .valid     (queue_valid),
        .full      (queue_full),
        .head      (head)
    );

    // Blend arithmetic and result register.
    sfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_item   (head),
        .span      (span),
        .recip     (recip),
        .pop       (pop),
        .out_valid (out_valid),
        .out_pix   (out_pix)
    );

`ifndef SYNTH
    // Every accepted word leaves as a result after the queue and the back-end stages.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ##4 out_valid)
        else $error("accepted word did not produce a result in time");

    // No result without a matching accepted word.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(push, 4))
        else $error("result without a matching accepted word");

    // A window write must block input until the reciprocal is rebuilt.
    a_window_block: assert property (@(posedge clk) disable iff (!rst_n)
        recip_restart |=> busy)
        else $error("input open while the reciprocal is stale");
`endif

endmodule

`default_nettype wire
